// ----- rtl/lkv_pkg.sv -----
package lkv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the input transaction
        logic look;    // compare keys, pick victim and free slot
        logic commit;  // update entries and load the result register
    } t_ctl_cmd;

endpackage

// ----- rtl/lkv_datapath.sv -----
module lkv_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkv_pkg::t_ctl_cmd                 i_ctl,
    input  logic                              i_cmd,
    input  logic signed [lkv_pkg::KEY_W-1:0]  i_key,
    input  logic signed [lkv_pkg::DATA_W-1:0] i_value,
    input  logic                              i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_data,
    output logic                              o_found,
    output logic signed [lkv_pkg::DATA_W-1:0] o_data
);
    import lkv_pkg::*;

    // configuration and occupancy
    logic [CAP_W-1:0]  r_capacity;
    logic [CAP_W-1:0]  r_occ;

    // entry storage
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_rank [ENTRIES];
    logic [KEY_W-1:0]   r_key  [ENTRIES];
    logic [DATA_W-1:0]  r_data [ENTRIES];

    // captured transaction
    logic              r_cmd;
    logic [KEY_W-1:0]  r_in_key;
    logic [DATA_W-1:0] r_in_val;

    // lookup stage results
    logic              r_hit;
    logic              r_evict;
    logic [IDX_W-1:0]  r_tgt;
    logic [CAP_W-1:0]  r_limit;

    logic              r_found;
    logic [DATA_W-1:0] r_out;

    logic              n_hit;
    logic              n_evict;
    logic [IDX_W-1:0]  n_tgt;
    logic [CAP_W-1:0]  n_limit;
    logic [CAP_W-1:0]  eff_cap;
    logic [CAP_W-1:0]  occ_m1;

    // effective capacity: zero acts as one, saturate at entry count
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CAP_W'(1);
        end else if (r_capacity > CAP_W'(ENTRIES)) begin
            eff_cap = CAP_W'(ENTRIES);
        end else begin
            eff_cap = r_capacity;
        end
    end

    assign occ_m1 = r_occ - CAP_W'(1);

    // parallel key compare, LRU victim (rank occ-1) and first free slot
    always_comb begin
        logic             hit_f;
        logic             vic_f;
        logic             free_f;
        logic [IDX_W-1:0] hit_i;
        logic [IDX_W-1:0] vic_i;
        logic [IDX_W-1:0] free_i;
        hit_f  = 1'b0;
        vic_f  = 1'b0;
        free_f = 1'b0;
        hit_i  = '0;
        vic_i  = '0;
        free_i = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && r_key[i] == r_in_key && !hit_f) begin
                hit_f = 1'b1;
                hit_i = IDX_W'(i);
            end
            if (r_valid[i] && r_rank[i] == occ_m1[IDX_W-1:0] && !vic_f) begin
                vic_f = 1'b1;
                vic_i = IDX_W'(i);
            end
            if (!r_valid[i] && !free_f) begin
                free_f = 1'b1;
                free_i = IDX_W'(i);
            end
        end
        n_hit   = hit_f;
        n_evict = !hit_f && (r_occ >= eff_cap);
        if (hit_f) begin
            n_tgt   = hit_i;
            n_limit = {1'b0, r_rank[hit_i]};
        end else begin
            n_tgt   = n_evict ? vic_i : free_i;
            n_limit = CAP_W'(ENTRIES);
        end
    end

    // control state: capacity, occupancy, valid bits and ranks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_occ      <= '0;
            r_valid    <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_ctl.commit && (r_hit || r_cmd == CMD_PUT)) begin
                // age younger entries, target becomes most recent
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && IDX_W'(i) != r_tgt
                        && {1'b0, r_rank[i]} < r_limit) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                r_rank[r_tgt] <= '0;
                if (!r_hit) begin
                    r_valid[r_tgt] <= 1'b1;
                    if (!r_evict) begin
                        r_occ <= r_occ + CAP_W'(1);
                    end
                end
            end
        end
    end

    // payload: item capture, lookup results, entry data, result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_in_key <= i_key;
            r_in_val <= i_value;
        end
        if (i_ctl.look) begin
            r_hit   <= n_hit;
            r_evict <= n_evict;
            r_tgt   <= n_tgt;
            r_limit <= n_limit;
        end
        if (i_ctl.commit) begin
            r_found <= r_hit;
            if (r_cmd == CMD_PUT) begin
                r_out          <= r_in_val;
                r_data[r_tgt]  <= r_in_val;
                if (!r_hit) begin
                    r_key[r_tgt] <= r_in_key;
                end
            end else if (r_hit) begin
                r_out <= r_data[r_tgt];
            end else begin
                r_out <= '1;
            end
        end
    end

    assign o_found = r_found;
    assign o_data  = r_out;

endmodule

// ----- rtl/lkv_ctrl.sv -----
module lkv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output lkv_pkg::t_ctl_cmd o_ctl
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // result register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_ctl.load   = (r_state == S_IDLE) && i_in_valid;
        o_ctl.look   = (r_state == S_LOOK);
        o_ctl.commit = (r_state == S_UPD) && out_free;
    end

    // sequencer and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ctl.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// Fully associative key-value cache with 16 entries and least-recently-used
// replacement. Each transaction is a get (cmd 0) or put (cmd 1) and yields one
// result: found tells whether the key was present beforehand, data is the
// stored value on a get hit, all ones on a get miss, and the put value echoed
// on a put. A transaction is captured, then runs the parallel key compare and
// victim/free-slot search, then updates the entries and loads the result
// register, waiting while the output is stalled; the next transaction is
// taken in the cycle after that. Capacity (reset 16) is to be written through
// the config channel only while the cache is idle; the cache does not enforce
// this. Zero acts as one, above 16 as 16. The cache starts empty after reset.
module lru_key_value_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic signed [lkv_pkg::KEY_W-1:0]  i_key,
    input  logic signed [lkv_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic signed [lkv_pkg::DATA_W-1:0] o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]         i_cfg_data
);
    import lkv_pkg::*;

    t_ctl_cmd ctl;

    assign o_cfg_ready = 1'b1;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    lkv_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .i_value    (i_value),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_found    (o_found),
        .o_data     (o_data)
    );

endmodule
